// File: hdl/mrq_pkg.sv
// shared types, constants and codes of the multilevel ready queue
package mrq_pkg;

   // default configuration
   localparam int LEVELS_DEF  = 64;
   localparam int HANDLES_DEF = 256;

   // fixed field widths
   localparam int HANDLE_W = 8;
   localparam int LEVEL_W  = 6;
   localparam int COUNT_W  = 32;
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // lowest-set-bit search: bitmap split into groups of eight
   localparam int FIND_W  = 64;
   localparam int GROUP_W = 3;
   localparam int GROUPS  = FIND_W / (1 << GROUP_W);
   localparam int GROUP_N = 1 << GROUP_W;

   // request codes
   localparam logic REQ_ADD = 1'b0;
   localparam logic REQ_GET = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ADD,
      ST_GET_HEAD,
      ST_GET_LINK
   } state_type;

   typedef struct packed {
      logic               any;
      logic [LEVEL_W-1:0] idx;
   } find_type;

endpackage

// File: hdl/multilevel_ready_queue.sv
// top level of the multilevel ready queue of thread handles
//
// usage
// - a request word is taken at the rising edge where start is high and busy is low;
//   req_type selects add (append req_thread_handle to the tail of req_level) or get
//   (remove the head of the lowest-numbered non-empty level)
// - every request yields exactly one result word, shown for a single cycle with
//   rsp_valid high; the receiver cannot stall, so it must take the word then
// - result carries found, the handle taken (zero when nothing found) and the
//   saturating hit and miss counters as they stand after the request
// - an add passes through ST_ADD and a get of a queued thread through ST_GET_HEAD
//   and ST_GET_LINK before its result word is registered; a get on an empty queue
//   and an add with an out-of-range level or handle register it at the accepting edge
// - a new request may be accepted in the cycle the previous result is shown,
//   but not before, as busy stays high until then; the head, tail and link
//   memories have registered reads, so an add reads the level word before writing it,
//   and a get chains a head read into a link read before the head write-back
// - reset clears the level bitmap, the counters and the control state; head,
//   tail and link memories are not cleared, the bitmap alone says which levels
//   hold valid lists
module multilevel_ready_queue
   import mrq_pkg::*;
#(
   parameter int LEVELS  = LEVELS_DEF,
   parameter int HANDLES = HANDLES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_type,
   input  logic [HANDLE_W-1:0] req_thread_handle,
   input  logic [LEVEL_W-1:0]  req_level,
   output logic                rsp_valid,
   output logic                rsp_found,
   output logic [HANDLE_W-1:0] rsp_out_handle,
   output logic [COUNT_W-1:0]  rsp_hit_count,
   output logic [COUNT_W-1:0]  rsp_miss_count
);

   localparam int LIDX_W = $clog2(LEVELS);
   localparam int HIDX_W = $clog2(HANDLES);

   // state memories: per-level word holds {head, tail}, link indexed by handle
   logic [2*HANDLE_W-1:0] level_mem [LEVELS];
   logic [HANDLE_W-1:0]   link_mem [HANDLES];

   state_type state_ff, state_in;

   logic [LEVELS-1:0]   nonempty_ff, nonempty_in;
   logic [COUNT_W-1:0]  hits_ff, hits_in;
   logic [COUNT_W-1:0]  misses_ff, misses_in;
   logic [LIDX_W-1:0]   level_ff;
   logic [HANDLE_W-1:0] handle_ff;
   logic [HANDLE_W-1:0] head_rd_ff;
   logic [HANDLE_W-1:0] tail_rd_ff;
   logic [HANDLE_W-1:0] link_rd_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_found_ff, rsp_found_in;
   logic [HANDLE_W-1:0] rsp_out_handle_ff, rsp_out_handle_in;

   find_type            find_ff;

   logic                take;
   logic                add_ok;
   logic [LIDX_W-1:0]   rd_level;

   // control from the output decoder
   logic                mem_rd_en;
   logic                link_rd_en;
   logic                head_we;
   logic                tail_we;
   logic                link_we;
   logic [HANDLE_W-1:0] head_wdata;
   logic                bit_set;
   logic                bit_clr;
   logic                hit_inc;
   logic                miss_inc;

   // lowest non-empty level, kept in step with the bitmap register
   mrq_find_first u_find (
      .clock   (clock),
      .reset   (reset),
      .bits_in (FIND_W'(nonempty_in)),
      .find_ff (find_ff)
   );

   assign busy = (state_ff != ST_IDLE);
   assign take = start && !busy;

   // adds outside the configured level or handle range are dropped
   assign add_ok = (32'(req_level) < LEVELS) && (32'(req_thread_handle) < HANDLES);
   assign rd_level = (req_type == REQ_ADD) ? LIDX_W'(req_level) : LIDX_W'(find_ff.idx);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               if (req_type == REQ_ADD && add_ok) begin
                  state_in = ST_ADD;
               end else if (req_type == REQ_GET && find_ff.any) begin
                  state_in = ST_GET_HEAD;
               end
            end
         end
         ST_ADD:      state_in = ST_IDLE;
         ST_GET_HEAD: state_in = ST_GET_LINK;
         ST_GET_LINK: state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      mem_rd_en         = 1'b0;
      link_rd_en        = 1'b0;
      head_we           = 1'b0;
      tail_we           = 1'b0;
      link_we           = 1'b0;
      head_wdata        = handle_ff;
      bit_set           = 1'b0;
      bit_clr           = 1'b0;
      hit_inc           = 1'b0;
      miss_inc          = 1'b0;
      rsp_valid_in      = 1'b0;
      rsp_found_in      = 1'b0;
      rsp_out_handle_in = '0;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               if (req_type == REQ_ADD) begin
                  if (add_ok) begin
                     mem_rd_en = 1'b1;
                  end else begin
                     rsp_valid_in = 1'b1;
                  end
               end else if (find_ff.any) begin
                  mem_rd_en = 1'b1;
               end else begin
                  // all levels empty
                  miss_inc     = 1'b1;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_ADD: begin
            // append behind the old tail, or start a fresh list
            if (nonempty_ff[level_ff]) begin
               link_we = 1'b1;
            end else begin
               head_we = 1'b1;
            end
            tail_we      = 1'b1;
            bit_set      = 1'b1;
            rsp_valid_in = 1'b1;
         end
         ST_GET_HEAD: begin
            link_rd_en = 1'b1;
         end
         ST_GET_LINK: begin
            // level empties when its head is its tail
            if (head_rd_ff == tail_rd_ff) begin
               bit_clr = 1'b1;
            end else begin
               head_we    = 1'b1;
               head_wdata = link_rd_ff;
            end
            hit_inc           = 1'b1;
            rsp_valid_in      = 1'b1;
            rsp_found_in      = 1'b1;
            rsp_out_handle_in = head_rd_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      nonempty_in = nonempty_ff;
      if (bit_set) begin
         nonempty_in[level_ff] = 1'b1;
      end
      if (bit_clr) begin
         nonempty_in[level_ff] = 1'b0;
      end
      hits_in   = (hit_inc && hits_ff != COUNT_MAX) ? hits_ff + 1'b1 : hits_ff;
      misses_in = (miss_inc && misses_ff != COUNT_MAX) ? misses_ff + 1'b1 : misses_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         nonempty_ff  <= '0;
         hits_ff      <= '0;
         misses_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         nonempty_ff  <= nonempty_in;
         hits_ff      <= hits_in;
         misses_ff    <= misses_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request and result words
   always_ff @(posedge clock) begin
      if (take) begin
         level_ff  <= rd_level;
         handle_ff <= req_thread_handle;
      end
      rsp_found_ff      <= rsp_found_in;
      rsp_out_handle_ff <= rsp_out_handle_in;
   end

   // level memory, one read port and one write port; the half not updated
   // is written back as it was read for this request
   always_ff @(posedge clock) begin
      if (mem_rd_en) begin
         {head_rd_ff, tail_rd_ff} <= level_mem[rd_level];
      end
      if (head_we || tail_we) begin
         level_mem[level_ff] <= {(head_we ? head_wdata : head_rd_ff),
                                 (tail_we ? handle_ff : tail_rd_ff)};
      end
   end

   // link memory indexed by handle
   always_ff @(posedge clock) begin
      if (link_rd_en) begin
         link_rd_ff <= link_mem[HIDX_W'(head_rd_ff)];
      end
      if (link_we) begin
         link_mem[HIDX_W'(tail_rd_ff)] <= handle_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_out_handle = rsp_out_handle_ff;
   assign rsp_hit_count  = hits_ff;
   assign rsp_miss_count = misses_ff;

   // a result word is only shown once the block is free again
   a_rsp_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   // an add in progress delivers its word in the next cycle
   a_add_responds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADD) |=> (rsp_valid && !rsp_found))
      else $error("add did not respond");

   // a get in progress works on a level marked non-empty
   a_get_level_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GET_HEAD || state_ff == ST_GET_LINK) |-> nonempty_ff[level_ff])
      else $error("get on empty level");

   // a word without a thread carries a zero handle
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_out_handle == '0))
      else $error("handle set without found");

endmodule

// File: hdl/mrq_find_first.sv
// registered search for the lowest set bit of the non-empty level bitmap
module mrq_find_first
   import mrq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [FIND_W-1:0] bits_in,
   output find_type          find_ff
);

   find_type            find_in;
   logic [GROUPS-1:0]   group_any;
   logic [GROUP_W-1:0]  group_sel;
   logic [GROUP_N-1:0]  group_bits;
   logic [GROUP_W-1:0]  bit_sel;

   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         group_any[g] = |bits_in[g*GROUP_N +: GROUP_N];
      end
      // descending scan so the lowest group wins
      group_sel = '0;
      for (int g = GROUPS - 1; g >= 0; g--) begin
         if (group_any[g]) begin
            group_sel = GROUP_W'(g);
         end
      end
      group_bits = bits_in[group_sel*GROUP_N +: GROUP_N];
      bit_sel = '0;
      for (int b = GROUP_N - 1; b >= 0; b--) begin
         if (group_bits[b]) begin
            bit_sel = GROUP_W'(b);
         end
      end
      find_in.any = |group_any;
      find_in.idx = {group_sel, bit_sel};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         find_ff.any <= 1'b0;
      end else begin
         find_ff <= find_in;
      end
   end

endmodule

// File: tb/multilevel_ready_queue_tb.sv
// testbench for the multilevel ready queue: directed and random add/get words, scoreboard check
`timescale 1ns / 100ps

module multilevel_ready_queue_tb;
   import mrq_pkg::*;

   localparam int NUM_LEVELS  = LEVELS_DEF;
   localparam int NUM_HANDLES = HANDLES_DEF;
   // far above the slowest clean run: ~825 words plus long sender gaps
   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE      = 8;

   // one result word as the block shows it
   typedef struct {
      logic                found;
      logic [HANDLE_W-1:0] handle;
      logic [COUNT_W-1:0]  hits;
      logic [COUNT_W-1:0]  misses;
   } result_word_type;

   // keeps its own copy of the level lists and counters, predicts each result word
   class ready_queue_scoreboard;
      bit [NUM_LEVELS-1:0] nonempty;
      bit [HANDLE_W-1:0]   head [NUM_LEVELS];
      bit [HANDLE_W-1:0]   tail [NUM_LEVELS];
      bit [HANDLE_W-1:0]   link [NUM_HANDLES];
      bit [COUNT_W-1:0]    hits;
      bit [COUNT_W-1:0]    misses;
      bit [NUM_LEVELS-1:0] levels_added;
      result_word_type     awaited[$];
      int                  errors;
      int                  adds;
      int                  gets;

      function new();
         nonempty     = '0;
         hits         = '0;
         misses       = '0;
         levels_added = '0;
         errors       = 0;
         adds         = 0;
         gets         = 0;
      endfunction

      task report_mismatch(input string what);
         $display("mismatch at %0t: %s", $time, what);
         errors++;
      endtask

      // apply an accepted request word to the lists and queue up its result
      task note_request(input logic kind, input logic [HANDLE_W-1:0] handle,
                        input logic [LEVEL_W-1:0] lvl);
         result_word_type w;
         logic            hit;
         int              l;
         w.found  = 1'b0;
         w.handle = '0;
         if (kind == REQ_ADD) begin
            adds++;
            if (lvl < NUM_LEVELS && handle < NUM_HANDLES) begin
               if (nonempty[lvl])
                  link[tail[lvl]] = handle;
               else
                  head[lvl] = handle;
               tail[lvl]         = handle;
               nonempty[lvl]     = 1'b1;
               levels_added[lvl] = 1'b1;
            end
         end else begin
            gets++;
            hit = 1'b0;
            for (l = 0; l < NUM_LEVELS && !hit; l++) begin
               if (nonempty[l]) begin
                  hit      = 1'b1;
                  w.found  = 1'b1;
                  w.handle = head[l];
                  // a level ends at its tail, not at a null link
                  if (head[l] == tail[l])
                     nonempty[l] = 1'b0;
                  else
                     head[l] = link[head[l]];
               end
            end
            if (hit) begin
               if (hits != COUNT_MAX) hits++;
            end else begin
               if (misses != COUNT_MAX) misses++;
            end
         end
         w.hits   = hits;
         w.misses = misses;
         awaited.push_back(w);
      endtask

      task check_result(input logic found, input logic [HANDLE_W-1:0] handle,
                        input logic [COUNT_W-1:0] hit_cnt, input logic [COUNT_W-1:0] miss_cnt);
         result_word_type w;
         if (awaited.size() == 0) begin
            report_mismatch("result word with nothing expected");
         end else begin
            w = awaited.pop_front();
            if (found !== w.found)
               report_mismatch($sformatf("found %b, expected %b", found, w.found));
            if (handle !== w.handle)
               report_mismatch($sformatf("handle %0d, expected %0d", handle, w.handle));
            if (hit_cnt !== w.hits)
               report_mismatch($sformatf("hit count %0d, expected %0d", hit_cnt, w.hits));
            if (miss_cnt !== w.misses)
               report_mismatch($sformatf("miss count %0d, expected %0d", miss_cnt, w.misses));
         end
      endtask
   endclass

   // block ports; the inputs are all known from time zero
   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic                req_type = REQ_ADD;
   logic [HANDLE_W-1:0] req_thread_handle = '0;
   logic [LEVEL_W-1:0]  req_level = '0;
   logic                rsp_valid;
   logic                rsp_found;
   logic [HANDLE_W-1:0] rsp_out_handle;
   logic [COUNT_W-1:0]  rsp_hit_count;
   logic [COUNT_W-1:0]  rsp_miss_count;

   ready_queue_scoreboard board;
   int                    cycles;

   multilevel_ready_queue DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_type          (req_type),
      .req_thread_handle (req_thread_handle),
      .req_level         (req_level),
      .rsp_valid         (rsp_valid),
      .rsp_found         (rsp_found),
      .rsp_out_handle    (rsp_out_handle),
      .rsp_hit_count     (rsp_hit_count),
      .rsp_miss_count    (rsp_miss_count)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // result words last one cycle and cannot be held off, so take every strobe
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         board.check_result(rsp_found, rsp_out_handle, rsp_hit_count, rsp_miss_count);
   end

   // present one request word and hold it until the block takes it
   // start is left high so the next word can follow without a gap
   task automatic send_word(input logic kind, input logic [HANDLE_W-1:0] handle,
                            input logic [LEVEL_W-1:0] lvl);
      start             <= 1'b1;
      req_type          <= kind;
      req_thread_handle <= handle;
      req_level         <= lvl;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_request(kind, handle, lvl);
   endtask

   // sender idles each cycle with the given chance in a hundred
   task automatic sender_gaps(input int pct);
      while ($urandom_range(0, 99) < pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   // hold off new words until every result has come back
   task automatic drain_pause();
      start <= 1'b0;
      @(posedge clock);
      while (board.awaited.size() != 0) @(posedge clock);
   endtask

   // extremes of every field, priority order, duplicate handles, empty-queue gets
   task automatic directed_words();
      send_word(REQ_GET, 8'h00, 6'd0);     // get on an empty queue: miss
      send_word(REQ_GET, 8'hff, 6'd63);    // fields ignored by a get
      send_word(REQ_ADD, 8'h00, 6'd63);    // lowest handle, lowest priority
      send_word(REQ_ADD, 8'hff, 6'd0);     // highest handle, top priority
      send_word(REQ_ADD, 8'haa, 6'h2a);
      send_word(REQ_ADD, 8'h55, 6'h15);
      send_word(REQ_ADD, 8'h12, 6'd0);     // second entry behind 0xff on level 0
      send_word(REQ_GET, 8'h00, 6'd0);     // 0xff
      send_word(REQ_GET, 8'h00, 6'd0);     // 0x12, level 0 empties
      send_word(REQ_GET, 8'h00, 6'd0);     // 0x55 from level 21
      send_word(REQ_GET, 8'h00, 6'd0);     // 0xaa from level 42
      send_word(REQ_GET, 8'h00, 6'd0);     // 0x00 from level 63
      send_word(REQ_GET, 8'h00, 6'd0);     // all empty again
      // re-add of a handle still queued: relinked, list ends early at the new tail
      send_word(REQ_ADD, 8'h07, 6'd5);
      send_word(REQ_ADD, 8'h09, 6'd5);
      send_word(REQ_ADD, 8'h07, 6'd5);
      send_word(REQ_GET, 8'h00, 6'd0);
      // same handle twice in a row links to itself
      send_word(REQ_ADD, 8'h03, 6'd5);
      send_word(REQ_ADD, 8'h03, 6'd5);
      send_word(REQ_GET, 8'h00, 6'd0);
      send_word(REQ_GET, 8'h00, 6'd0);
      // a lower level added later still wins
      send_word(REQ_ADD, 8'h40, 6'd63);
      send_word(REQ_ADD, 8'h80, 6'd1);
      send_word(REQ_GET, 8'h00, 6'd0);
      send_word(REQ_GET, 8'h00, 6'd0);
   endtask

   // random words: bursts that fill or drain, a few busy levels, small handles for repeats
   task automatic random_words(input int count, input int idle_pct);
      logic [LEVEL_W-1:0]  hot [4];
      logic [LEVEL_W-1:0]  lvl;
      logic [HANDLE_W-1:0] handle;
      logic                kind;
      int                  get_pct;
      int                  i;
      int                  j;
      get_pct = 50;
      for (i = 0; i < count; i++) begin
         if (i % 20 == 0) begin
            case ($urandom_range(0, 2))
               0: get_pct = 25;
               1: get_pct = 50;
               default: get_pct = 75;
            endcase
            for (j = 0; j < 4; j++) hot[j] = LEVEL_W'($urandom_range(0, NUM_LEVELS - 1));
         end
         kind   = ($urandom_range(0, 99) < get_pct) ? REQ_GET : REQ_ADD;
         lvl    = ($urandom_range(0, 99) < 60) ? hot[2'($urandom_range(0, 3))]
                                               : LEVEL_W'($urandom_range(0, NUM_LEVELS - 1));
         handle = ($urandom_range(0, 99) < 30) ? HANDLE_W'($urandom_range(0, 7))
                                               : HANDLE_W'($urandom_range(0, NUM_HANDLES - 1));
         sender_gaps(idle_pct);
         send_word(kind, handle, lvl);
      end
   endtask

   // watchdog
   initial begin
      for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clock);
      $display("timeout after %0d cycles", cycles);
      $display("multilevel_ready_queue_tb: done, errors");
      $finish;
   end

   initial begin
      board = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      directed_words();
      drain_pause();

      // light sender gaps, then heavy gaps, then back to back
      random_words(300, 8);
      drain_pause();
      random_words(250, 49);
      drain_pause();
      random_words(250, 0);

      start <= 1'b0;
      @(posedge clock);
      while (board.awaited.size() != 0) @(posedge clock);
      // a stray late word would show up here
      repeat (SETTLE) @(posedge clock);

      $display("covered %0d request words: %0d adds over %0d of %0d levels, %0d gets",
               board.adds + board.gets, board.adds, $countones(board.levels_added),
               NUM_LEVELS, board.gets);
      $display("gets that found a thread: %0d, gets on an empty queue: %0d",
               board.hits, board.misses);
      if (board.errors == 0)
         $display("multilevel_ready_queue_tb: done, clean");
      else
         $display("multilevel_ready_queue_tb: done, errors");
      $finish;
   end

endmodule

// File: filelist.f
hdl/mrq_pkg.sv
hdl/mrq_find_first.sv
hdl/multilevel_ready_queue.sv
tb/multilevel_ready_queue_tb.sv
